// File: design/cartridge_bank_controller_defines.svh
// assertion macros for the cartridge bank controller checker
// expects signals named clk and rst in the scope of each use
`ifndef CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH
`define CARTRIDGE_BANK_CONTROLLER_DEFINES_SVH

// same-cycle implication, off while in reset
`define CBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbc check failed");

// next-cycle implication, off while in reset
`define CBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbc check failed");

// next-cycle implication that also holds across reset
`define CBC_ASSERT_NXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cbc check failed");

`endif

// File: design/cbc_pkg.sv
// shared constants for the cartridge bank controller
// no dependencies; used by every design module
`default_nettype none

package cbc_pkg;

  localparam int RAM_BANKS_MAX  = 4;
  localparam int RAM_BANK_BYTES = 8192;
  localparam int ROM_BANK_BYTES = 16384;

  localparam int ADDR_W     = 16;
  localparam int DATA_W     = 8;
  localparam int ROM_BANK_W = 7;
  localparam int ROM_OFS_W  = $clog2(ROM_BANK_BYTES);
  localparam int RAM_OFS_W  = $clog2(RAM_BANK_BYTES);
  localparam int ROM_ADDR_W = ROM_BANK_W + ROM_OFS_W;
  localparam int RAM_FULL_W = 2 + RAM_OFS_W;

  localparam int S_TDATA_W   = 24;
  localparam int M_TDATA_W   = 32;
  localparam int CFG_INDEX_W = 1;

  // 8 KiB regions of the bus address, from address bits 15:13
  localparam logic [2:0] RGN_RAM_EN   = 3'd0;
  localparam logic [2:0] RGN_ROM_LOW  = 3'd1;
  localparam logic [2:0] RGN_UPPER    = 3'd2;
  localparam logic [2:0] RGN_MODE     = 3'd3;
  localparam logic [2:0] RGN_CART_RAM = 3'd5;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ROM_BANKS = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RAM_BANKS = 1'b1;

  localparam logic [3:0]        RAM_EN_KEY    = 4'hA;
  localparam logic [DATA_W-1:0] OPEN_BUS_BYTE = 8'hFF;
  localparam logic [7:0]        ROM_BANKS_RST = 8'd2;

endpackage

`default_nettype wire

// File: design/cartridge_bank_controller.sv
// Cartridge bank controller: takes one bus access per cycle when the result side is not stalled.
// A read result is registered first in the decode stage, beside the registered read of the
// cartridge RAM, then in the output register; writes give no result. After reset the block
// sweeps the RAM to zero, one byte a cycle, over RAM_BANKS_MAX * 8192 bytes (32768 by default),
// and takes no access until the sweep ends; configuration writes are taken at any time. ROM reads
// return a mapped 21-bit ROM byte address with read_data 0xFF.
// depends on cbc_pkg and cbc_ram
`default_nettype none

module cartridge_bank_controller #(
  parameter int RAM_BANKS_MAX = cbc_pkg::RAM_BANKS_MAX
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [cbc_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // address[15:0], write_data[23:16]
  input  logic                              s_axis_tuser,  // kind
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [cbc_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // read_data[7:0], rom_address[28:8]
  output logic                              m_axis_tuser,  // rom_read
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [cbc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [7:0]                        cfg_data
);

  localparam int RAM_DEPTH = RAM_BANKS_MAX * cbc_pkg::RAM_BANK_BYTES;
  localparam int RAM_AW    = $clog2(RAM_DEPTH);
  localparam logic [2:0]        BANKS_MAX_C = 3'(RAM_BANKS_MAX);
  localparam logic [RAM_AW-1:0] CLR_LAST    = RAM_AW'(RAM_DEPTH - 1);

  // configuration and banking registers
  logic [7:0] rom_bank_count;
  logic [2:0] ram_bank_count;
  logic       ram_enabled;
  logic [4:0] rom_bank_low;
  logic [1:0] upper_bank;
  logic       banking_mode;

  logic              clearing;
  logic [RAM_AW-1:0] clr_addr;

  logic                              s1_valid;
  logic                              s1_ram_hit;
  logic                              s1_rom_read;
  logic [cbc_pkg::ROM_ADDR_W-1:0]    s1_rom_addr;
  logic                              out_valid;
  logic [cbc_pkg::DATA_W-1:0]        out_read_data;
  logic                              out_rom_read;
  logic [cbc_pkg::ROM_ADDR_W-1:0]    out_rom_addr;

  logic                              in_kind;
  logic [cbc_pkg::ADDR_W-1:0]        in_addr;
  logic [cbc_pkg::DATA_W-1:0]        in_wdata;
  logic                              in_acc;
  logic [2:0]                        region;
  logic [2:0]                        ram_banks;
  logic [1:0]                        ram_bank_raw;
  logic [1:0]                        ram_bank_sel;
  logic [cbc_pkg::RAM_FULL_W-1:0]    ram_full;
  logic [RAM_AW-1:0]                 ram_idx;
  logic                              ram_ok;
  logic [7:0]                        rom_mask;
  logic [cbc_pkg::ROM_BANK_W-1:0]    rom_bank_raw;
  logic [cbc_pkg::ROM_BANK_W-1:0]    rom_bank;
  logic                              is_rom;
  logic [cbc_pkg::ROM_ADDR_W-1:0]    rom_addr;
  logic                              s1_move;

  logic                              ram_we;
  logic [RAM_AW-1:0]                 ram_waddr;
  logic [cbc_pkg::DATA_W-1:0]        ram_wdata;
  logic                              ram_re;
  logic [cbc_pkg::DATA_W-1:0]        ram_rdata;

  assign in_kind  = s_axis_tuser;
  assign in_addr  = s_axis_tdata[15:0];
  assign in_wdata = s_axis_tdata[23:16];
  assign in_acc   = s_axis_tvalid & s_axis_tready;
  assign region   = in_addr[15:13];

  // ram bank: present count clamped, bank reduced modulo that count
  assign ram_banks    = (ram_bank_count > BANKS_MAX_C) ? BANKS_MAX_C : ram_bank_count;
  assign ram_bank_raw = banking_mode ? upper_bank : 2'd0;

  always_comb begin
    case (ram_banks)
      3'd1:    ram_bank_sel = 2'd0;
      3'd2:    ram_bank_sel = {1'b0, ram_bank_raw[0]};
      3'd3:    ram_bank_sel = (ram_bank_raw == 2'd3) ? 2'd0 : ram_bank_raw;
      default: ram_bank_sel = ram_bank_raw;
    endcase
  end

  assign ram_full = {ram_bank_sel, in_addr[cbc_pkg::RAM_OFS_W-1:0]};
  assign ram_idx  = ram_full[RAM_AW-1:0];
  assign ram_ok   = ram_enabled && (ram_banks != 3'd0) && (region == cbc_pkg::RGN_CART_RAM);

  // rom mapping, bank masked with count minus one (wraps to 0xff for a count of zero)
  assign rom_mask     = rom_bank_count - 8'd1;
  assign rom_bank_raw = in_addr[14] ? {upper_bank, rom_bank_low}
                      : (banking_mode ? {upper_bank, 5'd0} : 7'd0);
  assign rom_bank     = rom_bank_raw & rom_mask[cbc_pkg::ROM_BANK_W-1:0];
  assign is_rom       = !in_addr[15];
  assign rom_addr     = {rom_bank, in_addr[cbc_pkg::ROM_OFS_W-1:0]};

  assign s1_move       = s1_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !clearing && (!s1_valid || s1_move);
  assign cfg_ready     = 1'b1;

  assign ram_we    = clearing || (in_acc && in_kind && ram_ok);
  assign ram_waddr = clearing ? clr_addr : ram_idx;
  assign ram_wdata = clearing ? '0 : in_wdata;
  assign ram_re    = in_acc && !in_kind;

  cbc_ram #(
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank_count <= cbc_pkg::ROM_BANKS_RST;
      ram_bank_count <= 3'd0;
      ram_enabled    <= 1'b0;
      rom_bank_low   <= 5'd1;
      upper_bank     <= 2'd0;
      banking_mode   <= 1'b0;
      clearing       <= 1'b1;
      clr_addr       <= '0;
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == CLR_LAST) begin
          clearing <= 1'b0;
        end
      end

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          cbc_pkg::CFG_ROM_BANKS: rom_bank_count <= cfg_data;
          cbc_pkg::CFG_RAM_BANKS: ram_bank_count <= cfg_data[2:0];
          default: ;
        endcase
      end

      if (in_acc && in_kind) begin
        unique case (region)
          cbc_pkg::RGN_RAM_EN:  ram_enabled  <= (in_wdata[3:0] == cbc_pkg::RAM_EN_KEY);
          cbc_pkg::RGN_ROM_LOW: rom_bank_low <= (in_wdata[4:0] == 5'd0) ? 5'd1 : in_wdata[4:0];
          cbc_pkg::RGN_UPPER:   upper_bank   <= in_wdata[1:0];
          cbc_pkg::RGN_MODE:    banking_mode <= in_wdata[0];
          default: ;
        endcase
      end

      // only reads produce a result
      if (in_acc) begin
        s1_valid <= !in_kind;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end

      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ram_hit  <= ram_ok;
      s1_rom_read <= is_rom;
      s1_rom_addr <= is_rom ? rom_addr : '0;
    end
    if (s1_move) begin
      out_read_data <= s1_ram_hit ? ram_rdata : cbc_pkg::OPEN_BUS_BYTE;
      out_rom_read  <= s1_rom_read;
      out_rom_addr  <= s1_rom_addr;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_rom_read;
  assign m_axis_tdata  = {3'd0, out_rom_addr, out_read_data};

endmodule

`default_nettype wire

// File: design/cbc_ram.sv
// cartridge ram storage: one write port, one read port, registered read data
// uses cbc_pkg for the byte width
`default_nettype none

module cbc_ram #(
  parameter int DEPTH = cbc_pkg::RAM_BANKS_MAX * cbc_pkg::RAM_BANK_BYTES,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [cbc_pkg::DATA_W-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [cbc_pkg::DATA_W-1:0] rdata
);

  logic [cbc_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // rdata holds until the next read so a stalled result keeps its byte
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/cbc_checker.sv
// port-level checks for the cartridge bank controller, bound to the top level
// depends on cbc_pkg and cartridge_bank_controller_defines.svh
`default_nettype none
`include "cartridge_bank_controller_defines.svh"

module cbc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [cbc_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  input logic                            m_axis_tuser
);

  // a stalled result transaction keeps its contents
  `CBC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // rom reads carry the open bus byte, everything else a zero rom address
  `CBC_ASSERT_IMP(a_rom_byte, m_axis_tvalid && m_axis_tuser, m_axis_tdata[7:0] == cbc_pkg::OPEN_BUS_BYTE)
  `CBC_ASSERT_IMP(a_non_rom_addr, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[28:8] == 21'd0)

  // the ram sweep after reset blocks accesses
  `CBC_ASSERT_NXT_ANY(a_sweep_block, rst, !s_axis_tready)

endmodule

bind cartridge_bank_controller cbc_checker u_cbc_checker (.*);

`default_nettype wire

// File: dv/cartridge_bank_controller_tb.sv
`timescale 1ns / 100ps
// testbench for cartridge_bank_controller: random and directed bus accesses checked
// against an in-bench bank mapping model; depends on cbc_pkg and the controller rtl

module cartridge_bank_controller_tb;

  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;
  localparam int   NUM_PHASES = 9;

  typedef struct packed {
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        hold;  // wait for all read results before this transaction
  } bus_access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        rom_read;
    logic [20:0] rom_address;
  } bus_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [cbc_pkg::S_TDATA_W-1:0]   s_axis_tdata = '0;  // address[15:0], write_data[23:16]
  logic                            s_axis_tuser = 1'b0;  // kind
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [cbc_pkg::M_TDATA_W-1:0]   m_axis_tdata;  // read_data[7:0], rom_address[28:8]
  logic                            m_axis_tuser;  // rom_read
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [cbc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]                      cfg_data = '0;

  cartridge_bank_controller dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #4 clk = ~clk;

  // mapping model state
  logic [7:0] rom_banks_cfg = cbc_pkg::ROM_BANKS_RST;
  logic [2:0] ram_banks_cfg = 3'd0;
  logic       ram_on        = 1'b0;
  logic [4:0] low_bank      = 5'd1;
  logic [1:0] upper_sel     = 2'd0;
  logic       bank_mode     = 1'b0;
  logic [7:0] cart_ram_shadow [cbc_pkg::RAM_BANKS_MAX*cbc_pkg::RAM_BANK_BYTES];

  bus_access_t access_q[$];
  bus_result_t read_results_q[$];
  bus_access_t cur_access = '0;
  logic [cbc_pkg::CFG_INDEX_W-1:0] cfg_idx_q[$];
  logic [7:0]                      cfg_val_q[$];

  int  items_queued = 0;
  int  items_accepted = 0;
  int  reads_issued = 0;
  int  results_checked = 0;
  int  cfg_queued = 0;
  int  cfg_accepted = 0;
  int  errors = 0;
  int  gap_left = 0;
  int  stall_left = 0;
  bit  src_calm = 1'b0;
  bit  sink_calm = 1'b0;
  bit  drv_busy;
  bit  drv_read;
  int  n_reads = 0, n_writes = 0, n_rom_reads = 0, n_ram_hits = 0;

  // mostly short gaps, a few long ones, none while calm
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic map_access(input bus_access_t acc, output bit produced);
    bus_result_t res;
    logic [7:0]  rom_bank;
    int unsigned ram_cnt;
    int unsigned ram_idx;
    produced = 1'b0;
    ram_cnt = (ram_banks_cfg > cbc_pkg::RAM_BANKS_MAX) ? cbc_pkg::RAM_BANKS_MAX : ram_banks_cfg;
    ram_idx = 0;
    if (ram_cnt != 0)
      ram_idx = ((bank_mode ? upper_sel : 0) % ram_cnt) * cbc_pkg::RAM_BANK_BYTES
                + acc.address[12:0];
    if (acc.kind == KIND_WRITE) begin
      n_writes++;
      case (acc.address[15:13])
        cbc_pkg::RGN_RAM_EN:   ram_on = (acc.write_data[3:0] == cbc_pkg::RAM_EN_KEY);
        cbc_pkg::RGN_ROM_LOW:  low_bank = (acc.write_data[4:0] == 5'd0) ? 5'd1
                                                                         : acc.write_data[4:0];
        cbc_pkg::RGN_UPPER:    upper_sel = acc.write_data[1:0];
        cbc_pkg::RGN_MODE:     bank_mode = acc.write_data[0];
        cbc_pkg::RGN_CART_RAM: begin
          if (ram_on && ram_cnt != 0) cart_ram_shadow[ram_idx] = acc.write_data;
        end
        default: ;
      endcase
    end else begin
      n_reads++;
      res = '{read_data: cbc_pkg::OPEN_BUS_BYTE, rom_read: 1'b0, rom_address: '0};
      if (!acc.address[15]) begin
        // upper half of rom space uses the switchable bank
        if (acc.address[14]) rom_bank = {1'b0, upper_sel, low_bank};
        else rom_bank = bank_mode ? {1'b0, upper_sel, 5'd0} : 8'd0;
        rom_bank = rom_bank & (rom_banks_cfg - 8'd1);
        res.rom_read = 1'b1;
        res.rom_address = {rom_bank[6:0], acc.address[13:0]};
        n_rom_reads++;
      end else if (acc.address[15:13] == cbc_pkg::RGN_CART_RAM && ram_on && ram_cnt != 0) begin
        res.read_data = cart_ram_shadow[ram_idx];
        n_ram_hits++;
      end
      read_results_q.push_back(res);
      produced = 1'b1;
    end
  endtask

  task automatic drv_cfg_step();
    bit busy;
    busy = cfg_valid;
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == cbc_pkg::CFG_ROM_BANKS) rom_banks_cfg = cfg_data;
      else if (cfg_index == cbc_pkg::CFG_RAM_BANKS) ram_banks_cfg = cfg_data[2:0];
      cfg_accepted <= cfg_accepted + 1;
      busy = 1'b0;
    end
    if (!busy && cfg_idx_q.size() != 0) begin
      cfg_index <= cfg_idx_q.pop_front();
      cfg_data <= cfg_val_q.pop_front();
      busy = 1'b1;
    end
    cfg_valid <= busy;
  endtask

  // access driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      drv_busy = s_axis_tvalid;
      drv_read = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        map_access(cur_access, drv_read);
        items_accepted <= items_accepted + 1;
        reads_issued <= reads_issued + drv_read;
        drv_busy = 1'b0;
      end
      if (!drv_busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (access_q.size() != 0 &&
                     !(access_q[0].hold && reads_issued + drv_read != results_checked)) begin
          cur_access = access_q.pop_front();
          gap_left = pick_gap(src_calm);
          if ($urandom_range(0, 63) == 0) src_calm = !src_calm;
          drv_busy = 1'b1;
        end
      end
      s_axis_tvalid <= drv_busy;
      s_axis_tuser <= cur_access.kind;
      s_axis_tdata <= {cur_access.write_data, cur_access.address};
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (read_results_q.size() == 0) begin
          $error("unexpected result transaction: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          errors++;
        end else begin
          bus_result_t want;
          want = read_results_q.pop_front();
          if (m_axis_tdata[7:0] !== want.read_data) begin
            $error("read_data: expected %h, actual %h", want.read_data, m_axis_tdata[7:0]);
            errors++;
          end
          if (m_axis_tuser !== want.rom_read) begin
            $error("rom_read: expected %b, actual %b", want.rom_read, m_axis_tuser);
            errors++;
          end
          if (m_axis_tdata[28:8] !== want.rom_address) begin
            $error("rom_address: expected %h, actual %h", want.rom_address, m_axis_tdata[28:8]);
            errors++;
          end
        end
        results_checked <= results_checked + 1;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = pick_gap(sink_calm);
        if ($urandom_range(0, 31) == 0) sink_calm = !sink_calm;
      end
      m_axis_tready <= (stall_left == 0);
    end
  end

  // configuration writer
  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else begin
      drv_cfg_step();
    end
  end

  task automatic push_access(input logic kind, input logic [15:0] address,
                             input logic [7:0] write_data, input logic hold = 1'b0);
    access_q.push_back('{kind: kind, address: address, write_data: write_data, hold: hold});
    items_queued++;
  endtask

  task automatic wait_idle();
    while (items_accepted != items_queued || reads_issued != results_checked ||
           cfg_accepted != cfg_queued)
      @(posedge clk);
    // writes still in the pipeline give no result
    repeat (6) @(posedge clk);
  endtask

  task automatic set_banks(input logic [7:0] rom_banks, input logic [7:0] ram_banks);
    wait_idle();
    cfg_idx_q.push_back(cbc_pkg::CFG_ROM_BANKS);
    cfg_val_q.push_back(rom_banks);
    cfg_idx_q.push_back(cbc_pkg::CFG_RAM_BANKS);
    cfg_val_q.push_back(ram_banks);
    cfg_queued += 2;
    wait_idle();
  endtask

  function automatic logic [12:0] pick_ram_offset();
    if ($urandom_range(0, 9) < 7)
      return $urandom_range(0, 1) ? 13'($urandom_range(0, 15)) : 13'h1FF0 + 13'($urandom_range(0, 15));
    return 13'($urandom);
  endfunction

  task automatic add_random(input int count);
    int          r;
    logic [15:0] addr;
    logic [7:0]  wdata;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      wdata = 8'($urandom);
      if (r < 8) begin
        if ($urandom_range(0, 9) < 7) wdata[3:0] = cbc_pkg::RAM_EN_KEY;
        push_access(KIND_WRITE, {cbc_pkg::RGN_RAM_EN, 13'($urandom)}, wdata, i == count / 2);
      end else if (r < 16) begin
        push_access(KIND_WRITE, {cbc_pkg::RGN_ROM_LOW, 13'($urandom)}, wdata, i == count / 2);
      end else if (r < 22) begin
        push_access(KIND_WRITE, {cbc_pkg::RGN_UPPER, 13'($urandom)}, wdata, i == count / 2);
      end else if (r < 27) begin
        push_access(KIND_WRITE, {cbc_pkg::RGN_MODE, 13'($urandom)}, wdata, i == count / 2);
      end else if (r < 55) begin
        push_access(KIND_READ, {1'b0, 15'($urandom)}, wdata, i == count / 2);
      end else if (r < 72) begin
        push_access(KIND_WRITE, {cbc_pkg::RGN_CART_RAM, pick_ram_offset()}, wdata,
                    i == count / 2);
      end else if (r < 92) begin
        push_access(KIND_READ, {cbc_pkg::RGN_CART_RAM, pick_ram_offset()}, wdata,
                    i == count / 2);
      end else begin
        // unmapped space: video ram window or above the cartridge ram
        addr = $urandom_range(0, 1) ? 16'h8000 + 16'($urandom_range(0, 16'h1FFF))
                                    : 16'hC000 + 16'($urandom_range(0, 16'h3FFF));
        push_access(1'($urandom), addr, wdata, i == count / 2);
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [7:0] rom_settings [NUM_PHASES];
    logic [7:0] ram_settings [NUM_PHASES];
    rom_settings = '{8'd2, 8'd128, 8'd64, 8'd4, 8'd16, 8'd0, 8'd48, 8'd32, 8'd8};
    ram_settings = '{8'd0, 8'd1,   8'd4,  8'd2, 8'd3,  8'd7, 8'd5,  8'd4,  8'd1};
    foreach (cart_ram_shadow[i]) cart_ram_shadow[i] = 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_banks(8'd128, 8'd4);
    push_access(KIND_READ,  16'h0000, 8'h00);
    push_access(KIND_READ,  16'h3FFF, 8'hFF);
    push_access(KIND_READ,  16'h4000, 8'h00);
    push_access(KIND_READ,  16'h7FFF, 8'h00);
    push_access(KIND_WRITE, 16'h2000, 8'h00);  // bank zero turns into one
    push_access(KIND_WRITE, 16'h3FFF, 8'hFF);
    push_access(KIND_READ,  16'h4000, 8'h00);
    push_access(KIND_WRITE, 16'h5FFF, 8'hFF);
    push_access(KIND_READ,  16'h7FFF, 8'h00);
    push_access(KIND_WRITE, 16'h6000, 8'h01);
    push_access(KIND_READ,  16'h0000, 8'h00);
    push_access(KIND_READ,  16'hA000, 8'h00, 1'b1);  // ram still disabled
    push_access(KIND_WRITE, 16'h0000, 8'h0A);
    push_access(KIND_WRITE, 16'hA000, 8'h5A);
    push_access(KIND_WRITE, 16'hBFFF, 8'hA5);
    push_access(KIND_READ,  16'hA000, 8'h00);
    push_access(KIND_READ,  16'hBFFF, 8'h00);
    push_access(KIND_WRITE, 16'h6000, 8'hFE);
    push_access(KIND_READ,  16'hA000, 8'h00);
    push_access(KIND_WRITE, 16'h1FFF, 8'hF0);
    push_access(KIND_READ,  16'hA000, 8'h00);
    push_access(KIND_READ,  16'h8000, 8'h00);
    push_access(KIND_READ,  16'h9FFF, 8'h00);
    push_access(KIND_WRITE, 16'hC000, 8'h77);
    push_access(KIND_READ,  16'hFFFF, 8'h00);

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_banks(rom_settings[p], ram_settings[p]);
      add_random(70);
    end
    wait_idle();

    $display("covered %0d reads (%0d rom, %0d ram hits) and %0d writes", n_reads,
             n_rom_reads, n_ram_hits, n_writes);
    $display("across %0d bank count settings, %0d results checked", NUM_PHASES + 1,
             results_checked);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
